FILE: rtl/core/cor_pkg.sv
// cor_pkg: shared constants and types for the circle outline rasterizer
// used by cor_front, cor_jobq, cor_back and circle_outline_rasterizer_core
package cor_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int JOBQ_DEPTH_DEFAULT = 2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [1:0] FIRST_SLOT = 2'd0;
  localparam logic [1:0] LAST_SLOT  = 2'd3;

  typedef struct packed {
    logic start;
    logic fin;
  } job_ctl_t;

  localparam int JOB_CTL_BITS = $bits(job_ctl_t);

endpackage

FILE: rtl/core/cor_front.sv
// cor_front: takes start and step transactions, keeps the offsets and error term,
// and hands one job per producing transaction to the job queue; uses cor_pkg
module cor_front import cor_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_acc,
  input  logic                         func,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-2:0]        radius,
  output logic                         job_push,
  output job_ctl_t                     job_ctl,
  output logic [COORD_BITS-1:0]        job_cx,
  output logic [COORD_BITS-1:0]        job_cy,
  output logic signed [COORD_BITS-1:0] job_x,
  output logic signed [COORD_BITS-1:0] job_y
);

  localparam int EW = COORD_BITS + 4;
  localparam logic signed [EW-1:0] ONE = 1;
  localparam logic signed [EW-1:0] TWO = 2;

  logic signed [COORD_BITS-1:0] offset_a;
  logic signed [COORD_BITS-1:0] offset_b;
  logic signed [EW-1:0]         step_error;
  logic                         active;
  logic [COORD_BITS-1:0]        held_center_x;
  logic [COORD_BITS-1:0]        held_center_y;

  logic signed [EW-1:0] a_w, b_w, b1_w, e1_w, a1_w, e2_w, start_error;
  logic                 cond_b, cond_a, fin;
  logic [EW-1:0]        radius_ext;
  logic [COORD_BITS-1:0] neg_radius;
  logic                 is_start;

  always_comb begin
    a_w    = {{(EW-COORD_BITS){offset_a[COORD_BITS-1]}}, offset_a};
    b_w    = {{(EW-COORD_BITS){offset_b[COORD_BITS-1]}}, offset_b};
    cond_b = step_error <= b_w;
    b1_w   = cond_b ? b_w + ONE : b_w;
    e1_w   = cond_b ? step_error + (b1_w <<< 1) + ONE : step_error;
    cond_a = (step_error > a_w) || (e1_w > b1_w);
    a1_w   = cond_a ? a_w + ONE : a_w;
    e2_w   = cond_a ? e1_w + (a1_w <<< 1) + ONE : e1_w;
    fin    = !a1_w[EW-1];
    radius_ext  = {{(EW-COORD_BITS+1){1'b0}}, radius};
    neg_radius  = ~{1'b0, radius} + 1'b1;
    start_error = TWO - $signed(radius_ext << 1);
  end

  assign is_start = (func == FUNC_START);
  assign job_push = in_acc && (is_start || active);

  always_comb begin
    job_ctl.start = is_start;
    job_ctl.fin   = !is_start && fin;
    job_cx        = is_start ? center_x : held_center_x;
    job_cy        = is_start ? center_y : held_center_y;
    job_x         = is_start ? '0 : offset_a;
    job_y         = is_start ? '0 : offset_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_a      <= '0;
      offset_b      <= '0;
      step_error    <= '0;
      active        <= 1'b0;
      held_center_x <= '0;
      held_center_y <= '0;
    end else if (in_acc) begin
      if (is_start) begin
        held_center_x <= center_x;
        held_center_y <= center_y;
        offset_a      <= $signed(neg_radius);
        offset_b      <= '0;
        step_error    <= start_error;
        active        <= 1'b1;
      end else if (active) begin
        offset_a   <= a1_w[COORD_BITS-1:0];
        offset_b   <= b1_w[COORD_BITS-1:0];
        step_error <= e2_w;
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_acc && !is_start && active && fin |=> !active)
    else $error("circle still active after its final step");

  assert property (@(posedge clk) disable iff (rst)
    active |-> offset_a[COORD_BITS-1] || (offset_a == '0 && offset_b == '0))
    else $error("x offset left its range while active");

  assert property (@(posedge clk) disable iff (rst)
    job_push && job_ctl.start |-> !job_ctl.fin)
    else $error("start job marked as final");

endmodule

FILE: rtl/core/cor_jobq.sv
// cor_jobq: small register queue of pending pixel jobs between front and back
// uses cor_pkg for the default depth
module cor_jobq import cor_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = JOBQ_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("job queue count overflow");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> !empty)
    else $error("queue empty right after a push");

endmodule

FILE: rtl/core/cor_back.sv
// cor_back: expands each job into its pixels in the output register, one per cycle
// while it is empty or popped; uses cor_pkg for the job control type and slot codes
module cor_back import cor_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  job_ctl_t                     q_ctl,
  input  logic [COORD_BITS-1:0]        q_cx,
  input  logic [COORD_BITS-1:0]        q_cy,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last,
  output logic                         done_res
);

  localparam int OB = COORD_BITS + 2;

  logic                         busy;
  logic [1:0]                   slot;
  job_ctl_t                     cur_ctl;
  logic [COORD_BITS-1:0]        cur_cx;
  logic [COORD_BITS-1:0]        cur_cy;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic                         ov;

  logic                 adv;
  logic                 load;
  logic signed [OB-1:0] cxe, cye, xe, ye, px, py;

  assign adv   = busy && (!ov || pop);
  assign load  = (!busy || (adv && slot == LAST_SLOT)) && !q_empty;
  assign q_pop = load;
  assign empty = !ov;

  always_comb begin
    cxe = $signed({2'b00, cur_cx});
    cye = $signed({2'b00, cur_cy});
    xe  = {{2{cur_x[COORD_BITS-1]}}, cur_x};
    ye  = {{2{cur_y[COORD_BITS-1]}}, cur_y};
    unique case (slot)
      2'd0: begin
        px = cxe - xe;
        py = cye + ye;
      end
      2'd1: begin
        px = cxe - ye;
        py = cye - xe;
      end
      2'd2: begin
        px = cxe + xe;
        py = cye - ye;
      end
      default: begin
        px = cxe + ye;
        py = cye + xe;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= FIRST_SLOT;
      ov   <= 1'b0;
    end else begin
      if (adv) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        slot <= q_ctl.start ? LAST_SLOT : FIRST_SLOT;
      end else if (adv) begin
        slot <= slot + 1'b1;
        if (slot == LAST_SLOT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_ctl <= q_ctl;
      cur_cx  <= q_cx;
      cur_cy  <= q_cy;
      cur_x   <= q_x;
      cur_y   <= q_y;
    end
    if (adv) begin
      pixel_x  <= px;
      pixel_y  <= py;
      last     <= (slot == LAST_SLOT);
      done_res <= (slot == LAST_SLOT) && cur_ctl.fin;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    adv && slot == LAST_SLOT |=> ov && last)
    else $error("last slot not flagged on output");

  assert property (@(posedge clk) disable iff (rst)
    ov && done_res |-> last)
    else $error("done without last");

  assert property (@(posedge clk) disable iff (rst)
    busy && !adv && !load |=> busy && $stable(slot))
    else $error("job slot moved while stalled");

endmodule

FILE: rtl/core/circle_outline_rasterizer_core.sv
// circle_outline_rasterizer_core: top level of the midpoint circle outline generator
// instantiates cor_front, cor_jobq and cor_back; uses cor_pkg
//
// input channel: push/full. a transaction with func = start loads center_x,
// center_y and radius and produces one pixel at the center (last = 1). a
// transaction with func = step produces four symmetric outline pixels, last on
// the fourth, done_res on the fourth of the step that ends the circle. a step
// while no circle is running produces nothing. a start while running restarts.
// output channel: empty/pop, the oldest pixel is on the ports while empty is low.
// each job goes through the job queue and the back's job registers to the ports.
// throughput: one pixel per cycle out of the output register while it is popped;
// the job queue lets the front take new transactions while the back is still
// emitting pixels.
// when pop stays low the output register holds, the back stops, the queue
// fills and full rises. reset empties the queue and output and makes the
// generator idle; there is no clearing pass.
module circle_outline_rasterizer_core import cor_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         func,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-2:0]        radius,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last,
  output logic                         done_res
);

  localparam int JW = JOB_CTL_BITS + 4 * COORD_BITS;

  logic                         in_acc;
  logic                         job_push;
  job_ctl_t                     job_ctl;
  logic [COORD_BITS-1:0]        job_cx, job_cy;
  logic signed [COORD_BITS-1:0] job_x, job_y;
  logic [JW-1:0]                wdata, rdata;
  logic                         q_empty, q_pop;
  job_ctl_t                     q_ctl;
  logic [COORD_BITS-1:0]        q_cx, q_cy;
  logic signed [COORD_BITS-1:0] q_x, q_y;

  assign in_acc = push && !full;
  assign wdata  = {job_ctl, job_cx, job_cy, job_x, job_y};
  assign {q_ctl, q_cx, q_cy, q_x, q_y} = rdata;

  cor_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_acc  (in_acc),
    .func    (func),
    .center_x(center_x),
    .center_y(center_y),
    .radius  (radius),
    .job_push(job_push),
    .job_ctl (job_ctl),
    .job_cx  (job_cx),
    .job_cy  (job_cy),
    .job_x   (job_x),
    .job_y   (job_y)
  );

  cor_jobq #(
    .W    (JW),
    .DEPTH(JOBQ_DEPTH_DEFAULT)
  ) u_jobq (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .wdata(wdata),
    .full (full),
    .pop  (q_pop),
    .rdata(rdata),
    .empty(q_empty)
  );

  cor_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_ctl   (q_ctl),
    .q_cx    (q_cx),
    .q_cy    (q_cy),
    .q_x     (q_x),
    .q_y     (q_y),
    .empty   (empty),
    .pop     (pop),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .last    (last),
    .done_res(done_res)
  );

endmodule
